// ----- sv/ace_pkg.sv -----
package ace_pkg;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] KIND_ANSWER  = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic [1:0] ST_FREE      = 2'd0;
    localparam logic [1:0] ST_OK        = 2'd1;
    localparam logic [1:0] ST_RESOLVING = 2'd2;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_OWN_IP          = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NET_MASK        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GATEWAY_ADDRESS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_LIFETIME  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REQUEST_WAIT    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RETRY_LIMIT     = 3'd5;

    localparam int MAX_OUT = 8;
    localparam int CNT_W   = 4;

    typedef struct packed {
        logic [31:0] own_ip;
        logic [31:0] net_mask;
        logic [31:0] gateway_address;
        logic [15:0] entry_lifetime;
        logic [15:0] request_wait;
        logic [7:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        found;
        logic [47:0] hw_address;
        logic [31:0] proto_address;
    } result_t;

    typedef struct packed {
        logic    push;
        logic    last;
        result_t res;
    } push_t;

endpackage

// ----- sv/ace_in_if.sv -----
interface ace_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic        is_request;
    logic [31:0] lookup_ip;

    modport source (output valid, operation, sender_ip, sender_mac, target_ip, is_request,
                    lookup_ip, input ready);
    modport sink (input valid, operation, sender_ip, sender_mac, target_ip, is_request,
                  lookup_ip, output ready);
endinterface

// ----- sv/ace_out_if.sv -----
interface ace_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        found;
    logic [47:0] hw_address;
    logic [31:0] proto_address;
    logic        last;

    modport source (output valid, result_kind, found, hw_address, proto_address, last,
                    input ready);
    modport sink (input valid, result_kind, found, hw_address, proto_address, last,
                  output ready);
endinterface

// ----- sv/ace_cfg_if.sv -----
interface ace_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [31:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ----- sv/ace_cfg_regs.sv -----
module ace_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    ace_cfg_if.sink       cfg_ch,
    output ace_pkg::cfg_t cfg
);
    import ace_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.addr)
                REG_OWN_IP:          cfg_next.own_ip          = cfg_ch.data;
                REG_NET_MASK:        cfg_next.net_mask        = cfg_ch.data;
                REG_GATEWAY_ADDRESS: cfg_next.gateway_address = cfg_ch.data;
                REG_ENTRY_LIFETIME:  cfg_next.entry_lifetime  = cfg_ch.data[15:0];
                REG_REQUEST_WAIT:    cfg_next.request_wait    = cfg_ch.data[15:0];
                REG_RETRY_LIMIT:     cfg_next.retry_limit     = cfg_ch.data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_ip          <= 32'd0;
            cfg_reg.net_mask        <= 32'hFFFF_FF00;
            cfg_reg.gateway_address <= 32'd0;
            cfg_reg.entry_lifetime  <= 16'd3000;
            cfg_reg.request_wait    <= 16'd10;
            cfg_reg.retry_limit     <= 8'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

// ----- sv/ace_out_stage.sv -----
module ace_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  ace_pkg::push_t push,
    output logic           can_flush,
    ace_out_if.source      out_ch
);
    import ace_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    last_reg;
    result_t item_reg;

    assign can_flush = !valid_reg || out_ch.ready;

    assign out_ch.valid         = valid_reg;
    assign out_ch.result_kind   = item_reg.result_kind;
    assign out_ch.found         = item_reg.found;
    assign out_ch.hw_address    = item_reg.hw_address;
    assign out_ch.proto_address = item_reg.proto_address;
    assign out_ch.last          = last_reg;

    always_comb
    begin
        if (push.push)
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            item_reg <= push.res;
            last_reg <= push.last;
        end
    end
endmodule

// ----- sv/ace_engine.sv -----
module ace_engine #(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ace_pkg::cfg_t  cfg,
    ace_in_if.sink         in_ch,
    input  logic           can_flush,
    output ace_pkg::push_t push
);
    import ace_pkg::*;

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_AGE    = 3'd3;
    localparam logic [2:0] S_EMIT_B = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0]  op_reg, op_next;
    logic [31:0] sip_reg, sip_next;
    logic [47:0] smac_reg, smac_next;
    logic [31:0] tip_reg, tip_next;
    logic        req_reg, req_next;
    logic [31:0] key_reg, key_next;
    logic        local_reg, local_next;
    logic        hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [47:0] hit_mac_reg, hit_mac_next;
    logic [15:0] hit_qc_reg, hit_qc_next;
    logic        free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [15:0] best_qc_reg, best_qc_next;
    logic        pend_valid_reg, pend_valid_next;
    result_t     pend_reg, pend_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [31:0] ip_reg [CACHE_ENTRIES];
    logic [31:0] ip_next [CACHE_ENTRIES];
    logic [47:0] mac_reg [CACHE_ENTRIES];
    logic [47:0] mac_next [CACHE_ENTRIES];
    logic [1:0]  st_reg [CACHE_ENTRIES];
    logic [1:0]  st_next [CACHE_ENTRIES];
    logic [15:0] cd_reg [CACHE_ENTRIES];
    logic [15:0] cd_next [CACHE_ENTRIES];
    logic [7:0]  ret_reg [CACHE_ENTRIES];
    logic [7:0]  ret_next [CACHE_ENTRIES];
    logic [15:0] qc_reg [CACHE_ENTRIES];
    logic [15:0] qc_next [CACHE_ENTRIES];

    logic        emit_req;
    result_t     emit_res;
    logic        emit_ok;
    logic        stall;
    logic [1:0]  cur_st;
    logic [15:0] cur_cd;
    logic [15:0] age_cd;
    logic [1:0]  age_st;
    logic [7:0]  age_ret;
    logic [IW-1:0] wr_idx;
    logic        in_off;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign cur_st      = st_reg[idx_reg];
    assign cur_cd      = cd_reg[idx_reg] - 16'd1;
    assign wr_idx      = hit_reg ? hit_idx_reg : (free_found_reg ? free_idx_reg : best_idx_reg);
    assign in_off      = ((in_ch.lookup_ip ^ cfg.own_ip) & cfg.net_mask) != 32'd0;

    // decide what this step wants to emit and how an aged entry changes
    always_comb
    begin
        emit_req = 1'b0;
        emit_res = '0;
        age_cd   = cur_cd;
        age_st   = cur_st;
        age_ret  = ret_reg[idx_reg];
        unique case (state_reg)
            S_UPDATE:
            begin
                if (op_reg == OP_PACKET)
                begin
                    emit_req = (tip_reg == cfg.own_ip) && req_reg;
                    emit_res = '{KIND_REPLY, 1'b0, smac_reg, sip_reg};
                end
                else
                begin
                    emit_req = 1'b1;
                    emit_res = '{KIND_ANSWER, hit_reg, hit_reg ? hit_mac_reg : 48'd0, key_reg};
                end
            end
            S_EMIT_B:
            begin
                emit_req = 1'b1;
                emit_res = '{KIND_REQUEST, 1'b0, 48'd0, key_reg};
            end
            S_AGE:
            begin
                emit_res = '{KIND_REQUEST, 1'b0, 48'd0, ip_reg[idx_reg]};
                if (cur_st != ST_FREE && cur_cd == 16'd0)
                begin
                    if (cur_st == ST_OK)
                    begin
                        emit_req = 1'b1;
                        age_cd   = cfg.request_wait;
                        age_st   = ST_RESOLVING;
                    end
                    else if (cur_st == ST_RESOLVING)
                    begin
                        if (ret_reg[idx_reg] != 8'd0)
                        begin
                            emit_req = 1'b1;
                            age_ret  = ret_reg[idx_reg] - 8'd1;
                            age_cd   = cfg.request_wait;
                        end
                        else
                        begin
                            age_st = ST_FREE;
                        end
                    end
                end
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign emit_ok = emit_req && (cnt_reg < CNT_W'(MAX_OUT));
    assign stall   = emit_ok && pend_valid_reg && !can_flush;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        sip_next        = sip_reg;
        smac_next       = smac_reg;
        tip_next        = tip_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        local_next      = local_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_mac_next    = hit_mac_reg;
        hit_qc_next     = hit_qc_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_idx_next   = best_idx_reg;
        best_qc_next    = best_qc_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        ip_next         = ip_reg;
        mac_next        = mac_reg;
        st_next         = st_reg;
        cd_next         = cd_reg;
        ret_next        = ret_reg;
        qc_next         = qc_reg;
        push            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_next         = in_ch.operation;
                    sip_next        = in_ch.sender_ip;
                    smac_next       = in_ch.sender_mac;
                    tip_next        = in_ch.target_ip;
                    req_next        = in_ch.is_request;
                    local_next      = ((in_ch.sender_ip ^ cfg.own_ip) & cfg.net_mask) == 32'd0;
                    key_next        = (in_ch.operation == OP_LOOKUP) ?
                                      (in_off ? cfg.gateway_address : in_ch.lookup_ip) :
                                      in_ch.sender_ip;
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    if (in_ch.operation == OP_PACKET || in_ch.operation == OP_LOOKUP)
                        state_next = S_SCAN;
                    else if (in_ch.operation == OP_TICK)
                        state_next = S_AGE;
                    else
                        state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (cur_st != ST_FREE && ip_reg[idx_reg] == key_reg && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                    hit_mac_next = mac_reg[idx_reg];
                    hit_qc_next  = qc_reg[idx_reg];
                end
                if (cur_st == ST_FREE && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (idx_reg == '0 || qc_reg[idx_reg] < best_qc_reg)
                begin
                    best_idx_next = idx_reg;
                    best_qc_next  = qc_reg[idx_reg];
                end
                if (idx_reg == LAST_IDX)
                    state_next = S_UPDATE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_UPDATE:
            begin
                if (!stall)
                begin
                    if (op_reg == OP_PACKET)
                    begin
                        if (local_reg)
                        begin
                            if (!hit_reg)
                            begin
                                ip_next[wr_idx] = sip_reg;
                                qc_next[wr_idx] = 16'd0;
                            end
                            mac_next[wr_idx] = smac_reg;
                            st_next[wr_idx]  = ST_OK;
                            cd_next[wr_idx]  = cfg.entry_lifetime;
                            ret_next[wr_idx] = cfg.retry_limit;
                        end
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        if (hit_reg && hit_qc_reg != 16'hFFFF)
                            qc_next[hit_idx_reg] = hit_qc_reg + 16'd1;
                        state_next = hit_reg ? S_FINISH : S_EMIT_B;
                    end
                end
            end
            S_EMIT_B:
            begin
                if (!stall)
                    state_next = S_FINISH;
            end
            S_AGE:
            begin
                if (!stall)
                begin
                    if (cur_st != ST_FREE)
                    begin
                        cd_next[idx_reg]  = age_cd;
                        st_next[idx_reg]  = age_st;
                        ret_next[idx_reg] = age_ret;
                    end
                    if (idx_reg == LAST_IDX)
                        state_next = S_FINISH;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                // the held item, or a nothing-to-do item, closes the input
                if (can_flush)
                begin
                    push.push  = 1'b1;
                    push.last  = 1'b1;
                    push.res   = pend_valid_reg ? pend_reg :
                                 '{KIND_NONE, 1'b0, 48'd0, 32'd0};
                    pend_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hold one result back so the final one can carry last
        if (emit_ok && !stall)
        begin
            if (pend_valid_reg)
            begin
                push.push = 1'b1;
                push.last = 1'b0;
                push.res  = pend_reg;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
            cnt_next        = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
                st_reg[i] <= ST_FREE;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            st_reg         <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        sip_reg        <= sip_next;
        smac_reg       <= smac_next;
        tip_reg        <= tip_next;
        req_reg        <= req_next;
        key_reg        <= key_next;
        local_reg      <= local_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_mac_reg    <= hit_mac_next;
        hit_qc_reg     <= hit_qc_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_idx_reg   <= best_idx_next;
        best_qc_reg    <= best_qc_next;
        pend_reg       <= pend_next;
        ip_reg         <= ip_next;
        mac_reg        <= mac_next;
        cd_reg         <= cd_next;
        ret_reg        <= ret_next;
        qc_reg         <= qc_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_OUT))
        else $error("result count exceeds limit");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> can_flush)
        else $error("result pushed into a full output stage");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg != S_IDLE))
        else $error("engine idle right after accepting an item");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (push.push && push.last) |=> (state_reg == S_IDLE && !pend_valid_reg))
        else $error("final result sent while work remains");
endmodule

// ----- sv/arp_cache_engine_top.sv -----
// Channel  | Role   | Payload
// in_ch    | sink   | operation, sender_ip, sender_mac, target_ip, is_request, lookup_ip
// out_ch   | source | result_kind, found, hw_address, proto_address, last
// cfg_ch   | sink   | addr (register index), data; always ready
//
// A packet or lookup scans every entry in turn and then updates the table,
// a miss adds a request step; a tick ages every entry in turn.
// in_ch.ready is high only between items. One result is held back inside the
// engine and one sits in the output register; a stalled out_ch holds the walk.
// Reset frees every entry at once through per-entry status flops.
module arp_cache_engine_top #(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    ace_in_if.sink    in_ch,
    ace_out_if.source out_ch,
    ace_cfg_if.sink   cfg_ch
);
    import ace_pkg::*;

    cfg_t  cfg;
    push_t push;
    logic  can_flush;

    ace_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    ace_engine #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_ch     (in_ch),
        .can_flush (can_flush),
        .push      (push)
    );

    ace_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .can_flush (can_flush),
        .out_ch    (out_ch)
    );
endmodule

// ----- tb/sv/arp_cache_engine_top_test.sv -----
module arp_cache_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ace_pkg::*;

    localparam int NUM_ENTRIES = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
        logic        is_request;
        logic [31:0] lookup_ip;
    } arp_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        found;
        logic [47:0] hw_address;
        logic [31:0] proto_address;
        logic        last;
    } arp_result_t;

    logic clk;
    logic rst_n;

    ace_in_if  in_ch ();
    ace_out_if out_ch ();
    ace_cfg_if cfg_ch ();

    arp_cache_engine_top #(.CACHE_ENTRIES(NUM_ENTRIES)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // Predictor copy of the configuration and the cache table
    cfg_t        cache_cfg;
    logic [31:0] tbl_ip [NUM_ENTRIES];
    logic [47:0] tbl_mac [NUM_ENTRIES];
    logic [1:0]  tbl_status [NUM_ENTRIES];
    logic [15:0] tbl_countdown [NUM_ENTRIES];
    logic [7:0]  tbl_retries [NUM_ENTRIES];
    logic [15:0] tbl_queries [NUM_ENTRIES];

    arp_item_t   pending_items[$];
    arp_result_t expected_results[$];

    int mismatch_count;
    int idle_pct_send;
    int idle_pct_recv;
    int stall_cycles;
    int watchdog;

    logic [2:0]  cfg_addr_q[$];
    logic [31:0] cfg_data_q[$];

    always #5 clk = ~clk;

    function automatic bit is_off_subnet(logic [31:0] ip);
        return ((ip ^ cache_cfg.own_ip) & cache_cfg.net_mask) != 32'd0;
    endfunction

    function automatic int find_cached(logic [31:0] ip);
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (tbl_status[i] != ST_FREE && tbl_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic void push_result(ref arp_result_t res_list[$], input logic [1:0] kind,
                                        input logic fnd, input logic [47:0] hw,
                                        input logic [31:0] ip);
        arp_result_t r;
        if (res_list.size() >= MAX_OUT)
            return;
        r.result_kind = kind;
        r.found = fnd;
        r.hw_address = hw;
        r.proto_address = ip;
        r.last = 1'b0;
        res_list.push_back(r);
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_OWN_IP:          cache_cfg.own_ip = val;
            REG_NET_MASK:        cache_cfg.net_mask = val;
            REG_GATEWAY_ADDRESS: cache_cfg.gateway_address = val;
            REG_ENTRY_LIFETIME:  cache_cfg.entry_lifetime = val[15:0];
            REG_REQUEST_WAIT:    cache_cfg.request_wait = val[15:0];
            REG_RETRY_LIMIT:     cache_cfg.retry_limit = val[7:0];
            default: ;
        endcase
    endfunction

    // Update the table for one item and queue the results it causes
    function automatic void predict_arp_item(arp_item_t it);
        arp_result_t res_list[$];
        logic [31:0] addr;
        int          slot;
        case (it.operation)
            OP_PACKET:
            begin
                if (!is_off_subnet(it.sender_ip))
                begin
                    slot = find_cached(it.sender_ip);
                    if (slot < 0)
                    begin
                        slot = -1;
                        for (int i = 0; i < NUM_ENTRIES && slot < 0; i++)
                            if (tbl_status[i] == ST_FREE)
                                slot = i;
                        if (slot < 0)
                        begin
                            slot = 0;
                            for (int i = 1; i < NUM_ENTRIES; i++)
                                if (tbl_queries[i] < tbl_queries[slot])
                                    slot = i;
                        end
                        tbl_ip[slot] = it.sender_ip;
                        tbl_queries[slot] = 16'd0;
                    end
                    tbl_mac[slot] = it.sender_mac;
                    tbl_status[slot] = ST_OK;
                    tbl_countdown[slot] = cache_cfg.entry_lifetime;
                    tbl_retries[slot] = cache_cfg.retry_limit;
                end
                if (it.target_ip == cache_cfg.own_ip && it.is_request)
                    push_result(res_list, KIND_REPLY, 1'b0, it.sender_mac, it.sender_ip);
            end
            OP_LOOKUP:
            begin
                addr = is_off_subnet(it.lookup_ip) ? cache_cfg.gateway_address : it.lookup_ip;
                slot = find_cached(addr);
                if (slot >= 0)
                begin
                    if (tbl_queries[slot] != 16'hFFFF)
                        tbl_queries[slot]++;
                    push_result(res_list, KIND_ANSWER, 1'b1, tbl_mac[slot], addr);
                end
                else
                begin
                    push_result(res_list, KIND_ANSWER, 1'b0, 48'd0, addr);
                    push_result(res_list, KIND_REQUEST, 1'b0, 48'd0, addr);
                end
            end
            OP_TICK:
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (tbl_status[i] != ST_FREE)
                        tbl_countdown[i] = tbl_countdown[i] - 16'd1;
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (tbl_status[i] == ST_FREE || tbl_countdown[i] != 16'd0)
                        continue;
                    if (tbl_status[i] == ST_OK)
                    begin
                        push_result(res_list, KIND_REQUEST, 1'b0, 48'd0, tbl_ip[i]);
                        tbl_countdown[i] = cache_cfg.request_wait;
                        tbl_status[i] = ST_RESOLVING;
                    end
                    else if (tbl_status[i] == ST_RESOLVING)
                    begin
                        if (tbl_retries[i] > 8'd0)
                        begin
                            tbl_retries[i]--;
                            push_result(res_list, KIND_REQUEST, 1'b0, 48'd0, tbl_ip[i]);
                            tbl_countdown[i] = cache_cfg.request_wait;
                        end
                        else
                            tbl_status[i] = ST_FREE;
                    end
                end
            end
            default: ;
        endcase
        if (res_list.size() == 0)
            push_result(res_list, KIND_NONE, 1'b0, 48'd0, 32'd0);
        res_list[res_list.size()-1].last = 1'b1;
        foreach (res_list[k])
            expected_results.push_back(res_list[k]);
    endfunction

    // Driver for items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.operation <= OP_TICK;
            in_ch.sender_ip <= '0;
            in_ch.sender_mac <= '0;
            in_ch.target_ip <= '0;
            in_ch.is_request <= 1'b0;
            in_ch.lookup_ip <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_arp_item(pending_items.pop_front());
            if ((!in_ch.valid || in_ch.ready) || !in_ch.valid)
            begin
                if (!(in_ch.valid && !in_ch.ready))
                begin
                    if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct_send)
                    begin
                        in_ch.valid <= 1'b1;
                        in_ch.operation <= pending_items[0].operation;
                        in_ch.sender_ip <= pending_items[0].sender_ip;
                        in_ch.sender_mac <= pending_items[0].sender_mac;
                        in_ch.target_ip <= pending_items[0].target_ip;
                        in_ch.is_request <= pending_items[0].is_request;
                        in_ch.lookup_ip <= pending_items[0].lookup_ip;
                    end
                    else
                        in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and ready generation for results
    always @(posedge clk or negedge rst_n)
    begin
        arp_result_t exp_r;
        arp_result_t got;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.result_kind = out_ch.result_kind;
                got.found = out_ch.found;
                got.hw_address = out_ch.hw_address;
                got.proto_address = out_ch.proto_address;
                got.last = out_ch.last;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: kind %0d ip %h", got.result_kind,
                                 got.proto_address);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected kind %0d found %0d mac %h ip %h ",
                                     exp_r.result_kind, exp_r.found, exp_r.hw_address,
                                     exp_r.proto_address,
                                     "last %0d, got kind %0d found %0d mac %h ip %h last %0d",
                                     exp_r.last, got.result_kind, got.found,
                                     got.hw_address, got.proto_address, got.last);
                    end
                end
            end
            if (stall_cycles > 0)
            begin
                stall_cycles <= stall_cycles - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= idle_pct_recv);
        end
    end

    // Configuration writer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.addr <= REG_OWN_IP;
            cfg_ch.data <= '0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                apply_cfg(cfg_addr_q.pop_front(), cfg_data_q.pop_front());
            if (!(cfg_ch.valid && !cfg_ch.ready))
            begin
                if (cfg_addr_q.size() > (cfg_ch.valid && cfg_ch.ready ? 0 : 0) &&
                    !(cfg_ch.valid && !cfg_ch.ready))
                begin
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.addr <= cfg_addr_q[0];
                    cfg_ch.data <= cfg_data_q[0];
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
        end
    end

    // Watchdog on accepted traffic
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_addr_q.push_back(idx);
        cfg_data_q.push_back(val);
        while (cfg_addr_q.size() > 0 || cfg_ch.valid)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
        begin
            @(posedge clk);
            if (watchdog >= WATCHDOG_LIMIT)
            begin
                $display("Timeout waiting for results");
                $display("FAIL");
                $finish;
            end
        end
        repeat (2 * NUM_ENTRIES + 8) @(posedge clk);
    endtask

    function automatic arp_item_t make_item(logic [1:0] op, logic [31:0] sip, logic [47:0] smac,
                                            logic [31:0] tip, logic req, logic [31:0] lip);
        arp_item_t it;
        it.operation = op;
        it.sender_ip = sip;
        it.sender_mac = smac;
        it.target_ip = tip;
        it.is_request = req;
        it.lookup_ip = lip;
        return it;
    endfunction

    function automatic logic [47:0] rand_mac();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // Mostly on-subnet addresses from a small pool, so hits and evictions happen
    function automatic logic [31:0] pick_ip();
        logic [31:0] ip;
        if ($urandom_range(9) < 8)
            ip = (cache_cfg.own_ip & cache_cfg.net_mask) |
                 ({$urandom_range(11)} & ~cache_cfg.net_mask);
        else
            ip = $urandom();
        return ip;
    endfunction

    task automatic random_phase(int count);
        arp_item_t it;
        int        sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
                it = make_item(OP_PACKET, pick_ip(), rand_mac(),
                               ($urandom_range(1) ? cache_cfg.own_ip : $urandom()),
                               rand_bit(), $urandom());
            else if (sel < 75)
                it = make_item(OP_LOOKUP, $urandom(), rand_mac(), $urandom(),
                               rand_bit(), pick_ip());
            else if (sel < 97)
                it = make_item(OP_TICK, $urandom(), rand_mac(), $urandom(),
                               rand_bit(), $urandom());
            else
                it = make_item(OP_NOP, $urandom(), rand_mac(), $urandom(),
                               rand_bit(), $urandom());
            pending_items.push_back(it);
        end
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        mismatch_count = 0;
        stall_cycles = 0;
        watchdog = 0;
        idle_pct_send = 0;
        idle_pct_recv = 0;
        cache_cfg.own_ip = 32'd0;
        cache_cfg.net_mask = 32'hFFFFFF00;
        cache_cfg.gateway_address = 32'd0;
        cache_cfg.entry_lifetime = 16'd3000;
        cache_cfg.request_wait = 16'd10;
        cache_cfg.retry_limit = 8'd3;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            tbl_status[i] = ST_FREE;
            tbl_ip[i] = '0;
            tbl_mac[i] = '0;
            tbl_countdown[i] = '0;
            tbl_retries[i] = '0;
            tbl_queries[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Short lifetimes so ticks expire, retry and free entries
        write_reg(REG_OWN_IP, 32'hC0A80101);
        write_reg(REG_NET_MASK, 32'hFFFFFF00);
        write_reg(REG_GATEWAY_ADDRESS, 32'hC0A80103);
        write_reg(REG_ENTRY_LIFETIME, 32'd2);
        write_reg(REG_REQUEST_WAIT, 32'd1);
        write_reg(REG_RETRY_LIMIT, 32'd1);

        idle_pct_send = 20;
        idle_pct_recv = 54;
        // Directed: request for us, refresh with new MAC, off-subnet reply, lookups
        pending_items.push_back(make_item(OP_PACKET, 32'hC0A80102, 48'hFFFFFFFFFFFF,
                                          32'hC0A80101, 1'b1, 32'd0));
        pending_items.push_back(make_item(OP_PACKET, 32'hC0A80102, 48'h000000000000,
                                          32'h00000000, 1'b0, 32'hFFFFFFFF));
        pending_items.push_back(make_item(OP_PACKET, 32'h0A000001, 48'h123456789ABC,
                                          32'hC0A80101, 1'b1, 32'd0));
        pending_items.push_back(make_item(OP_PACKET, 32'hC0A80103, 48'hA5A5A5A5A5A5,
                                          32'hC0A80101, 1'b0, 32'd0));
        pending_items.push_back(make_item(OP_LOOKUP, 32'd0, 48'd0, 32'd0, 1'b0, 32'hC0A80102));
        pending_items.push_back(make_item(OP_LOOKUP, 32'd0, 48'd0, 32'd0, 1'b0, 32'h08080808));
        pending_items.push_back(make_item(OP_LOOKUP, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF,
                                          32'hFFFFFFFF, 1'b1, 32'hC0A801FF));
        pending_items.push_back(make_item(OP_NOP, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF,
                                          32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF));
        // Fill all entries, then evict the least queried
        for (int i = 4; i < 13; i++)
            pending_items.push_back(make_item(OP_PACKET, 32'hC0A80100 + i, rand_mac(),
                                              32'd0, 1'b0, 32'd0));
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_item(OP_TICK, 32'd0, 48'd0, 32'd0, 1'b0, 32'd0));
        wait_drained();

        // Hold off the receiver while ticks stream in
        for (int i = 0; i < 8; i++)
            pending_items.push_back(make_item(OP_PACKET, 32'hC0A80110 + i, rand_mac(),
                                              32'd0, 1'b0, 32'd0));
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_item(OP_TICK, 32'd0, 48'd0, 32'd0, 1'b0, 32'd0));
        stall_cycles = 300;
        wait_drained();

        random_phase(55);

        idle_pct_send = 54;
        idle_pct_recv = 20;
        write_reg(REG_OWN_IP, 32'hFFFFFFFF);
        write_reg(REG_NET_MASK, 32'd0);
        write_reg(REG_GATEWAY_ADDRESS, 32'hFFFFFFFF);
        write_reg(REG_ENTRY_LIFETIME, 32'd65535);
        write_reg(REG_REQUEST_WAIT, 32'd65535);
        write_reg(REG_RETRY_LIMIT, 32'd255);
        random_phase(40);

        idle_pct_send = 0;
        idle_pct_recv = 0;
        write_reg(REG_OWN_IP, 32'h0A000001);
        write_reg(REG_NET_MASK, 32'hFFFFFFF0);
        write_reg(REG_GATEWAY_ADDRESS, 32'h0A000002);
        write_reg(REG_ENTRY_LIFETIME, 32'd1);
        write_reg(REG_REQUEST_WAIT, 32'd1);
        write_reg(REG_RETRY_LIMIT, 32'd0);
        random_phase(45);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if (rst_n && watchdog >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item accepted for %0d cycles", watchdog);
            $display("FAIL");
            $finish;
        end
    end

endmodule
